// ----- hw/rtl/bounded_array_list_engine_core_defines.svh -----
// Assertion macros for the array list engine core.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define BAL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bal_core: assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define BAL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bal_core: assertion failed");

`else

`define BAL_ASSERT_ALWAYS(lbl, prop)
`define BAL_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/bal_pkg.sv -----
`default_nettype none

package bal_pkg;

  // Storage geometry
  localparam int unsigned DEPTH      = 8;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCNT_W = 4;
  localparam int unsigned FIDX_W = 3;
  localparam int unsigned AT_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned REQ_W      = POS_W + VAL_W;
  localparam int unsigned RES_W      = STAT_W + VAL_W + OCNT_W + 1 + FIDX_W + VAL_W + VAL_W;
  localparam int unsigned S_TDATA_W  = ((REQ_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W  = ((RES_W + 7) / 8) * 8;

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_AT    = 3'd2,
    KIND_REM_FRONT = 3'd3,
    KIND_REM_BACK  = 3'd4,
    KIND_REM_AT    = 3'd5,
    KIND_WRITE_AT  = 3'd6,
    KIND_SEARCH    = 3'd7
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_BAD_POS   = 2'd3
  } status_e;

  // Walk pointer operations
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_TOP,
    PTR_AT,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  // Memory read address select
  typedef enum logic [1:0] {
    RA_PTR,
    RA_PTR_INC,
    RA_PTR_DEC
  } raddr_e;

  // Memory write select
  typedef enum logic [1:0] {
    WA_MOVE_UP,
    WA_MOVE_DN,
    WA_WORD
  } wsel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    req_load;
    logic    chk_load;
    ptr_op_e ptr_op;
    logic    rd_en;
    raddr_e  rd_sel;
    logic    wr_en;
    wsel_e   wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    keep_removed;
    logic    scan_clear;
    logic    scan_step;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
    logic err;
    logic at_eq_cnt;
    logic ptr_at;
    logic next_in;
    logic empty;
  } dp_stat_t;

  // Input payload, position in the low bits
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  // Result payload, status in the low bits
  typedef struct packed {
    logic signed [VAL_W-1:0] min_value;
    logic signed [VAL_W-1:0] max_value;
    logic [FIDX_W-1:0]       found_index;
    logic                    found;
    logic [OCNT_W-1:0]       count;
    logic signed [VAL_W-1:0] read_value;
    logic [STAT_W-1:0]       status;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bal_dp.sv -----
`default_nettype none

module bal_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bal_pkg::req_t     req_i,
  input  logic [bal_pkg::KIND_W-1:0] kind_i,
  input  bal_pkg::dp_cmd_t  cmd_i,
  output bal_pkg::dp_stat_t stat_o,
  output bal_pkg::res_t     res_o
);
  import bal_pkg::*;

  // Request and bookkeeping registers
  logic [KIND_W-1:0] kind_q;
  logic [POS_W-1:0]  pos_q;
  word_t             word_q;
  logic [CNT_W-1:0]  count_q;
  logic [AT_W-1:0]   at_q;
  logic [STAT_W-1:0] status_q;
  logic [IDX_W-1:0]  ptr_q;

  // Entry memory and read data
  word_t             mem_q [DEPTH];
  word_t             rdata_q;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  word_t             wdata;

  // Scan and removal results
  logic              removed_q;
  word_t             rm_word_q;
  word_t             top_q;
  word_t             mx_q;
  word_t             mn_q;
  logic              found_q;
  logic [IDX_W-1:0]  fidx_q;
  res_t              res_q;

  // Decode and check
  logic              is_ins;
  logic              is_rem;
  logic              is_wr;
  logic [AT_W-1:0]   at_c;
  logic [AT_W-1:0]   cnt_at;
  status_e           status_c;

  always_comb begin
    cnt_at   = AT_W'(count_q);
    is_ins   = 1'b0;
    is_rem   = 1'b0;
    is_wr    = 1'b0;
    at_c     = '0;
    status_c = STAT_OK;
    case (kind_e'(kind_q))
      KIND_INS_FRONT: begin
        is_ins = 1'b1;
        at_c   = '0;
      end
      KIND_INS_BACK: begin
        is_ins = 1'b1;
        at_c   = cnt_at;
      end
      KIND_INS_AT: begin
        is_ins = 1'b1;
        at_c   = AT_W'(pos_q);
      end
      KIND_REM_FRONT: begin
        is_rem = 1'b1;
        at_c   = '0;
      end
      KIND_REM_BACK: begin
        is_rem = 1'b1;
        at_c   = AT_W'(count_q - CNT_W'(1));
      end
      KIND_REM_AT: begin
        is_rem = 1'b1;
        at_c   = AT_W'(pos_q);
      end
      KIND_WRITE_AT: begin
        is_wr = 1'b1;
        at_c  = AT_W'(pos_q);
      end
      KIND_SEARCH: begin
        at_c = '0;
      end
      default: begin
        at_c = '0;
      end
    endcase

    if (is_ins) begin
      if (count_q >= CNT_W'(DEPTH)) begin
        status_c = STAT_OVERFLOW;
      end else if (at_c > cnt_at) begin
        status_c = STAT_BAD_POS;
      end
    end else if (is_rem) begin
      if (count_q == '0) begin
        status_c = STAT_UNDERFLOW;
      end else if (at_c >= cnt_at) begin
        status_c = STAT_BAD_POS;
      end
    end else if (is_wr) begin
      if (at_c >= cnt_at) begin
        status_c = STAT_BAD_POS;
      end
    end
  end

  // Status toward the controller
  always_comb begin
    stat_o.ins       = is_ins;
    stat_o.rem       = is_rem;
    stat_o.wr        = is_wr;
    stat_o.err       = (status_c != STAT_OK);
    stat_o.at_eq_cnt = (at_c == cnt_at);
    stat_o.ptr_at    = (AT_W'(ptr_q) == at_q);
    stat_o.next_in   = ((CNT_W'(ptr_q) + CNT_W'(1)) < count_q);
    stat_o.empty     = (count_q == '0);
  end

  // Memory address and data selection
  always_comb begin
    case (cmd_i.rd_sel)
      RA_PTR:     raddr = ptr_q;
      RA_PTR_INC: raddr = ptr_q + IDX_W'(1);
      RA_PTR_DEC: raddr = ptr_q - IDX_W'(1);
      default:    raddr = ptr_q;
    endcase
    case (cmd_i.wr_sel)
      WA_MOVE_UP: begin
        waddr = ptr_q + IDX_W'(1);
        wdata = rdata_q;
      end
      WA_MOVE_DN: begin
        waddr = ptr_q - IDX_W'(1);
        wdata = rdata_q;
      end
      WA_WORD: begin
        waddr = IDX_W'(at_q);
        wdata = word_q;
      end
      default: begin
        waddr = ptr_q;
        wdata = rdata_q;
      end
    endcase
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CNT_W'(1);
    end
  end

  // Walk pointer
  always_ff @(posedge clk_i) begin
    case (cmd_i.ptr_op)
      PTR_ZERO: ptr_q <= '0;
      PTR_TOP:  ptr_q <= IDX_W'(count_q - CNT_W'(1));
      PTR_AT:   ptr_q <= IDX_W'(at_c);
      PTR_INC:  ptr_q <= ptr_q + IDX_W'(1);
      PTR_DEC:  ptr_q <= ptr_q - IDX_W'(1);
      default:  ptr_q <= ptr_q;
    endcase
  end

  // Capture the request, the check result and the removed word
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q    <= kind_i;
      pos_q     <= req_i.position;
      word_q    <= WORD_WIDTH'(req_i.value);
      removed_q <= 1'b0;
    end
    if (cmd_i.chk_load) begin
      at_q     <= at_c;
      status_q <= status_c;
    end
    if (cmd_i.keep_removed) begin
      rm_word_q <= rdata_q;
      removed_q <= 1'b1;
    end
  end

  // Scan: track top, max, min and the first search match
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clear) begin
      found_q <= 1'b0;
      fidx_q  <= '0;
    end else if (cmd_i.scan_step) begin
      top_q <= rdata_q;
      if (ptr_q == '0) begin
        mx_q <= rdata_q;
        mn_q <= rdata_q;
      end else begin
        if ($signed(rdata_q) > $signed(mx_q)) begin
          mx_q <= rdata_q;
        end
        if ($signed(rdata_q) < $signed(mn_q)) begin
          mn_q <= rdata_q;
        end
      end
      if ((kind_q == KIND_SEARCH) && !found_q && (rdata_q == word_q)) begin
        found_q <= 1'b1;
        fidx_q  <= ptr_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.status      <= status_q;
      res_q.count       <= OCNT_W'(count_q);
      res_q.found       <= found_q;
      res_q.found_index <= FIDX_W'(fidx_q);
      if (removed_q) begin
        res_q.read_value <= VAL_W'(rm_word_q);
      end else if (count_q == '0) begin
        res_q.read_value <= '0;
      end else begin
        res_q.read_value <= VAL_W'(top_q);
      end
      if (count_q == '0) begin
        res_q.max_value <= '0;
        res_q.min_value <= '0;
      end else begin
        res_q.max_value <= VAL_W'(mx_q);
        res_q.min_value <= VAL_W'(mn_q);
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bal_ctrl.sv -----
`default_nettype none

module bal_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  bal_pkg::dp_stat_t stat_i,
  output bal_pkg::dp_cmd_t  cmd_o
);
  import bal_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_RD,
    S_INS_MV,
    S_PUT,
    S_REM_RD,
    S_REM_CAP,
    S_REM_MV,
    S_SCAN0,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DONE
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;

  // Sequence one request: check, shift, write, scan, deliver
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.chk_load = 1'b1;
        if (stat_i.err) begin
          state_d = S_SCAN0;
        end else if (stat_i.ins) begin
          if (stat_i.at_eq_cnt) begin
            state_d = S_PUT;
          end else begin
            cmd_o.ptr_op = PTR_TOP;
            state_d      = S_INS_RD;
          end
        end else if (stat_i.rem) begin
          cmd_o.ptr_op = PTR_AT;
          state_d      = S_REM_RD;
        end else if (stat_i.wr) begin
          state_d = S_PUT;
        end else begin
          state_d = S_SCAN0;
        end
      end
      S_INS_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_PTR;
        state_d      = S_INS_MV;
      end
      S_INS_MV: begin
        // move one entry up, walking down toward the insert point
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_MOVE_UP;
        if (stat_i.ptr_at) begin
          state_d = S_PUT;
        end else begin
          cmd_o.ptr_op = PTR_DEC;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_PTR_DEC;
        end
      end
      S_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WA_WORD;
        cmd_o.cnt_inc = stat_i.ins;
        state_d       = S_SCAN0;
      end
      S_REM_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_PTR;
        state_d      = S_REM_CAP;
      end
      S_REM_CAP: begin
        cmd_o.keep_removed = 1'b1;
        if (stat_i.next_in) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_PTR_INC;
          cmd_o.ptr_op = PTR_INC;
          state_d      = S_REM_MV;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_SCAN0;
        end
      end
      S_REM_MV: begin
        // move one entry down to close the gap
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WA_MOVE_DN;
        if (stat_i.next_in) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_PTR_INC;
          cmd_o.ptr_op = PTR_INC;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_SCAN0;
        end
      end
      S_SCAN0: begin
        cmd_o.ptr_op     = PTR_ZERO;
        cmd_o.scan_clear = 1'b1;
        state_d          = stat_i.empty ? S_DONE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RA_PTR;
        state_d      = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.next_in) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_PTR_INC;
          cmd_o.ptr_op = PTR_INC;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_array_list_engine_core.sv -----
// Channel    | Dir | Fields (lowest bit first)
// s_axis     | in  | tuser: kind[2:0]; tdata: position[2:0], value[34:3], zero pad
// m_axis     | out | tdata: status[1:0], read_value[33:2], count[37:34], found[38],
//            |     |        found_index[41:39], max_value[73:42], min_value[105:74], pad
//
// One item at a time. The shortest request finds the list empty and changes nothing;
// the longest is an insert at the front of a list of DEPTH - 1 entries: the entry
// memory moves one entry per cycle for a shift, then the max/min/search scan reads
// one entry per cycle.
// Reset clears the fill count, the controller state and the output valid; entries are not cleared.
// A result waits in the output register while the next item is taken; that item
// then holds in its last step until the output register is free.
`default_nettype none

`include "bounded_array_list_engine_core_defines.svh"

module bounded_array_list_engine_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // position, value, zero pad
  input  logic [bal_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  // kind
  input  logic [bal_pkg::KIND_W-1:0]        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // status, read_value, count, found, found_index, max_value, min_value, zero pad
  output logic [bal_pkg::M_TDATA_W-1:0]     m_axis_tdata_o
);
  import bal_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  req_t     req;
  res_t     res;

  assign req = s_axis_tdata_i[REQ_W-1:0];

  bal_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bal_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .kind_i (s_axis_tuser_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W - RES_W){1'b0}}, res};

  // Result consistency checks
  logic out_ovf;
  logic out_udf;
  logic out_found;

  assign out_ovf   = m_axis_tvalid_o && (res.status == STAT_OVERFLOW);
  assign out_udf   = m_axis_tvalid_o && (res.status == STAT_UNDERFLOW);
  assign out_found = m_axis_tvalid_o && res.found;

  `BAL_ASSERT_IMPL(a_ovf_full, out_ovf, res.count == OCNT_W'(DEPTH))
  `BAL_ASSERT_IMPL(a_udf_empty, out_udf, res.count == '0)
  `BAL_ASSERT_IMPL(a_found_ok, out_found, (res.status == STAT_OK) && (OCNT_W'(res.found_index) < res.count))
  `BAL_ASSERT_ALWAYS(a_max_ge_min, !m_axis_tvalid_o || (res.max_value >= res.min_value))

endmodule

`default_nettype wire
